### rtl/obm_pkg.sv
// shared types and constants of the price-level order book matcher
package obm_pkg;

    localparam int PRICE_W   = 10;
    localparam int QTY_W     = 32;
    localparam int CELL_SH   = 4;
    localparam int CELL_BITS = 1 << CELL_SH;
    localparam int CID_W     = PRICE_W - CELL_SH;
    localparam int MAX_CELLS = 1 << CID_W;
    localparam int LVL_W     = 6;

    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [QTY_W-1:0]   qty_t;

    localparam logic [1:0] K_LIMIT  = 2'd0;
    localparam logic [1:0] K_MARKET = 2'd1;
    localparam logic [1:0] K_CANCEL = 2'd2;
    localparam logic [1:0] K_UNUSED = 2'd3;

    localparam logic [2:0] ST_TRADE   = 3'd0;
    localparam logic [2:0] ST_FILLED  = 3'd1;
    localparam logic [2:0] ST_PARTIAL = 3'd2;
    localparam logic [2:0] ST_RESTED  = 3'd3;
    localparam logic [2:0] ST_REJECT  = 3'd4;
    localparam logic [2:0] ST_CANCEL  = 3'd5;

    localparam logic [LVL_W-1:0] LEVELS_RESET = 6'd20;

    // search token travelling along a chain of occupancy cells
    typedef struct packed {
        logic   valid;
        logic   found;
        price_t idx;
    } tok_t;

    // occupancy bit update broadcast to all cells
    typedef struct packed {
        logic   en;
        price_t idx;
        logic   set;
    } upd_t;

endpackage

### rtl/obm_cell.sv
// one occupancy cell: sixteen level bits and a search stage
module obm_cell #(
    parameter int ID = 0,
    parameter bit UP = 1'b1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  obm_pkg::upd_t                      upd,
    input  logic                               inject,
    input  obm_pkg::price_t                    start_idx,
    input  obm_pkg::tok_t                      tok_in,
    output obm_pkg::tok_t                      tok_out,
    output logic [obm_pkg::CELL_BITS-1:0]      bits
);
    import obm_pkg::*;

    localparam logic [CID_W-1:0] MY = CID_W'(ID);

    logic [CELL_BITS-1:0] bits_reg;
    tok_t                 tok_reg, tok_next;
    logic                 hit;
    price_t               hidx;
    logic                 is_start;

    always_comb
    begin
        price_t idx_b;
        logic   elig;
        int     bb;
        hit      = 1'b0;
        hidx     = '0;
        is_start = inject && (start_idx[PRICE_W-1:CELL_SH] == MY);
        for (int b = 0; b < CELL_BITS; b++)
        begin
            bb    = UP ? b : (CELL_BITS - 1 - b);
            idx_b = {MY, CELL_SH'(bb)};
            elig  = bits_reg[bb] &&
                    (!is_start || (UP ? (idx_b > start_idx) : (idx_b < start_idx)));
            if (elig && !hit)
            begin
                hit  = 1'b1;
                hidx = idx_b;
            end
        end
        if (is_start)
            tok_next = '{valid: 1'b1, found: hit, idx: hidx};
        else if (tok_in.valid && tok_in.found)
            tok_next = tok_in;
        else if (tok_in.valid)
            tok_next = '{valid: 1'b1, found: hit, idx: hidx};
        else
            tok_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (upd.en && (upd.idx[PRICE_W-1:CELL_SH] == MY))
                bits_reg[upd.idx[CELL_SH-1:0]] <= upd.set;
        end
    end

    assign tok_out = tok_reg;
    assign bits    = bits_reg;

endmodule

### rtl/obm_chain.sv
// row of occupancy cells for one book side with a directional search
module obm_chain #(
    parameter int NCELLS = 64,
    parameter bit UP     = 1'b1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  obm_pkg::upd_t   upd,
    input  logic            inject,
    input  obm_pkg::price_t start_idx,
    input  obm_pkg::price_t query,
    output logic            occ,
    output obm_pkg::tok_t   result
);
    import obm_pkg::*;

    tok_t                 tok_w [NCELLS+1];
    logic [CELL_BITS-1:0] bits_w [MAX_CELLS];

    genvar i;
    generate
        for (i = 0; i < MAX_CELLS; i++)
        begin : g_cell
            if (i < NCELLS)
            begin : g_live
                if (UP)
                begin : g_up
                    obm_cell #(.ID(i), .UP(UP)) u_cell (
                        .clk(clk), .rst_n(rst_n), .upd(upd), .inject(inject),
                        .start_idx(start_idx), .tok_in(tok_w[i]),
                        .tok_out(tok_w[i+1]), .bits(bits_w[i])
                    );
                end
                else
                begin : g_dn
                    obm_cell #(.ID(i), .UP(UP)) u_cell (
                        .clk(clk), .rst_n(rst_n), .upd(upd), .inject(inject),
                        .start_idx(start_idx), .tok_in(tok_w[i+1]),
                        .tok_out(tok_w[i]), .bits(bits_w[i])
                    );
                end
            end
            else
            begin : g_none
                assign bits_w[i] = '0;
            end
        end
        if (UP)
        begin : g_eu
            assign tok_w[0] = '0;
            assign result   = tok_w[NCELLS];
        end
        else
        begin : g_ed
            assign tok_w[NCELLS] = '0;
            assign result        = tok_w[0];
        end
    endgenerate

    assign occ = bits_w[query[PRICE_W-1:CELL_SH]][query[CELL_SH-1:0]];

endmodule

### rtl/price_level_order_book_matcher.sv
// top level: aggregated price-level book for one symbol with order matching
//
// input channel (in_valid/in_ready) takes one transaction per order: kind,
// side, price, quantity. output channel (out_valid/out_ready) gives one trade
// transaction per level touched, then one final status transaction (last=1).
// cfg_we/cfg_wdata write max_match_levels; the user must write it only while
// the block is idle, which the block itself does not enforce. one order at a
// time: in_ready is high only when the sequencer is idle, which it reaches as
// soon as the final status is loaded in the output register, so the next
// order may be taken while that status still waits. steps: a reject goes
// straight to its status; a cancel reads and updates its level, plus the
// occupancy search when it empties the best level; a match reads and takes
// from each level touched plus a search whenever a level is emptied, then
// rests and reports. a search runs through the row of 16-level cells, one
// cell per cycle. the level quantities sit in one memory per side;
// occupancy bits in the cells mark which entries hold lots, so reset clears
// only flip-flops and the block is ready in the first cycle after reset.
// a stalled receiver holds the output register and the sequencer waits
// in its emit state; nothing is lost or reordered.
module price_level_order_book_matcher #(
    parameter int PRICE_TICKS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    kind,
    input  logic                          side,
    input  obm_pkg::price_t               price,
    input  obm_pkg::qty_t                 quantity,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output obm_pkg::price_t               trade_price,
    output obm_pkg::qty_t                 trade_quantity,
    output obm_pkg::price_t               best_bid_out,
    output obm_pkg::price_t               best_ask_out,
    output obm_pkg::price_t               last_trade_price,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [obm_pkg::LVL_W-1:0]     cfg_wdata
);
    import obm_pkg::*;

    // prices at or above PRICE_TICKS never hold lots, so storage stops there
    localparam int DEPTH  = (PRICE_TICKS < (1 << PRICE_W)) ? PRICE_TICKS : (1 << PRICE_W);
    localparam int AW     = $clog2(DEPTH);
    localparam int NCELLS = (DEPTH + CELL_BITS - 1) / CELL_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_REJ, S_C_RD, S_C_UPD, S_C_SRCH, S_C_EMIT,
        S_W_CHECK, S_W_TAKE, S_W_SRCH, S_W_EMIT, S_FIN, S_R_ADD, S_F_EMIT
    } state_t;

    state_t            state_reg;
    logic [1:0]        kind_reg;
    logic              side_reg;
    price_t            price_reg;
    qty_t              qty_reg;
    qty_t              rem_reg;
    qty_t              filled_reg;
    qty_t              tq_reg;
    price_t            p_reg;
    logic [LVL_W-1:0]  touched_reg;
    logic [LVL_W-1:0]  levels_reg;
    price_t            bid_top_reg, ask_top_reg, last_reg;

    logic              out_valid_reg;
    logic [2:0]        status_reg;
    price_t            tp_reg;
    qty_t              oq_reg;
    price_t            obb_reg, oba_reg, olast_reg;
    logic              last_reg_o;

    // level memories
    qty_t              bid_mem [DEPTH];
    qty_t              ask_mem [DEPTH];
    qty_t              rd_bid_reg, rd_ask_reg;
    logic              rd_occ_reg;
    price_t            rd_addr;

    logic              bid_we, ask_we;
    price_t            wr_addr;
    qty_t              wr_data;

    upd_t              bid_upd, ask_upd;
    logic              bid_inj, ask_inj;
    price_t            srch_start;
    tok_t              bid_res, ask_res;
    logic              bid_occ, ask_occ;

    qty_t              rq, fill, newq, removed, cnewq, addq;
    logic [QTY_W:0]    sum;
    logic [LVL_W-1:0]  levels;
    logic              slot_free;
    logic              emit_now;
    logic              rej;
    logic              beyond;
    logic              can_srch;
    price_t            opp_best;

    assign levels    = (levels_reg == '0) ? LVL_W'(1) : levels_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    // an emit state loads the output register this cycle
    assign emit_now  = slot_free &&
                       (state_reg inside {S_REJ, S_C_EMIT, S_W_EMIT, S_F_EMIT});

    always_comb
    begin
        // read data of an entry never written is masked by its occupancy bit
        rq      = rd_occ_reg ? (side_reg ^ (state_reg == S_W_TAKE) ? rd_ask_reg : rd_bid_reg)
                             : '0;
        fill    = (rq < rem_reg) ? rq : rem_reg;
        newq    = rq - fill;
        removed = (rq < qty_reg) ? rq : qty_reg;
        cnewq   = rq - removed;
        sum     = {1'b0, rq} + {1'b0, rem_reg};
        addq    = sum[QTY_W] ? '1 : sum[QTY_W-1:0];
        rej     = (kind == K_UNUSED) || (quantity == '0) ||
                  ((kind != K_MARKET) &&
                   ((price == '0) || (32'(price) >= PRICE_TICKS)));
        beyond  = (kind_reg == K_LIMIT) &&
                  (side_reg ? (p_reg < price_reg) : (p_reg > price_reg));
        opp_best = side_reg ? bid_top_reg : ask_top_reg;
        can_srch = (cnewq == '0) && (rq != '0) &&
                   (price_reg == (side_reg ? ask_top_reg : bid_top_reg));
    end

    // memory read address, write port and search injection
    always_comb
    begin
        case (state_reg)
            S_W_CHECK: rd_addr = p_reg;
            default:   rd_addr = price_reg;
        endcase
        bid_we     = 1'b0;
        ask_we     = 1'b0;
        wr_addr    = price_reg;
        wr_data    = '0;
        bid_inj    = 1'b0;
        ask_inj    = 1'b0;
        srch_start = price_reg;
        case (state_reg)
            S_W_TAKE:
            begin
                wr_addr    = p_reg;
                wr_data    = newq;
                bid_we     = side_reg;
                ask_we     = !side_reg;
                srch_start = p_reg;
                bid_inj    = side_reg && (newq == '0);
                ask_inj    = !side_reg && (newq == '0);
            end
            S_C_UPD:
            begin
                wr_data = cnewq;
                bid_we  = !side_reg;
                ask_we  = side_reg;
                bid_inj = !side_reg && can_srch;
                ask_inj = side_reg && can_srch;
            end
            S_R_ADD:
            begin
                wr_data = addq;
                bid_we  = !side_reg;
                ask_we  = side_reg;
            end
            default:
            begin
                wr_data = '0;
            end
        endcase
        bid_upd = '{en: bid_we, idx: wr_addr, set: (wr_data != '0)};
        ask_upd = '{en: ask_we, idx: wr_addr, set: (wr_data != '0)};
    end

    always_ff @(posedge clk)
    begin
        if (bid_we)
            bid_mem[wr_addr[AW-1:0]] <= wr_data;
        if (ask_we)
            ask_mem[wr_addr[AW-1:0]] <= wr_data;
        rd_bid_reg <= bid_mem[rd_addr[AW-1:0]];
        rd_ask_reg <= ask_mem[rd_addr[AW-1:0]];
    end

    // occupancy of the entry just read, taken from the side being read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_occ_reg <= 1'b0;
        else if (state_reg == S_W_CHECK)
            rd_occ_reg <= side_reg ? bid_occ : ask_occ;
        else
            rd_occ_reg <= side_reg ? ask_occ : bid_occ;
    end

    // bid side searches downward for the next lower level, ask side upward
    obm_chain #(.NCELLS(NCELLS), .UP(1'b0)) u_bid_chain (
        .clk(clk), .rst_n(rst_n), .upd(bid_upd), .inject(bid_inj),
        .start_idx(srch_start), .query(rd_addr), .occ(bid_occ), .result(bid_res)
    );

    obm_chain #(.NCELLS(NCELLS), .UP(1'b1)) u_ask_chain (
        .clk(clk), .rst_n(rst_n), .upd(ask_upd), .inject(ask_inj),
        .start_idx(srch_start), .query(rd_addr), .occ(ask_occ), .result(ask_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            levels_reg    <= LEVELS_RESET;
            bid_top_reg   <= '0;
            ask_top_reg   <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= K_LIMIT;
            side_reg      <= 1'b0;
            touched_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                levels_reg <= cfg_wdata;
            // held while stalled, set when an emit state loads a transaction
            out_valid_reg <= emit_now || (out_valid_reg && !out_ready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg    <= kind;
                        side_reg    <= side;
                        price_reg   <= price;
                        qty_reg     <= quantity;
                        rem_reg     <= quantity;
                        filled_reg  <= '0;
                        touched_reg <= '0;
                        p_reg       <= side ? bid_top_reg : ask_top_reg;
                        if (rej)
                            state_reg <= S_REJ;
                        else if (kind == K_CANCEL)
                            state_reg <= S_C_RD;
                        else
                            state_reg <= S_W_CHECK;
                    end
                end
                S_REJ:
                begin
                    if (slot_free)
                    begin
                        status_reg    <= ST_REJECT;
                        tp_reg        <= '0;
                        oq_reg        <= '0;
                        obb_reg       <= bid_top_reg;
                        oba_reg       <= ask_top_reg;
                        olast_reg     <= last_reg;
                        last_reg_o    <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_C_RD:
                begin
                    state_reg <= S_C_UPD;
                end
                S_C_UPD:
                begin
                    tq_reg    <= removed;
                    state_reg <= can_srch ? S_C_SRCH : S_C_EMIT;
                end
                S_C_SRCH:
                begin
                    if (!side_reg && bid_res.valid)
                    begin
                        bid_top_reg <= bid_res.found ? bid_res.idx : '0;
                        state_reg   <= S_C_EMIT;
                    end
                    else if (side_reg && ask_res.valid)
                    begin
                        ask_top_reg <= ask_res.found ? ask_res.idx : '0;
                        state_reg   <= S_C_EMIT;
                    end
                end
                S_C_EMIT:
                begin
                    if (slot_free)
                    begin
                        status_reg    <= ST_CANCEL;
                        tp_reg        <= '0;
                        oq_reg        <= tq_reg;
                        obb_reg       <= bid_top_reg;
                        oba_reg       <= ask_top_reg;
                        olast_reg     <= last_reg;
                        last_reg_o    <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_W_CHECK:
                begin
                    // walk ends on an empty side, a filled order, the level
                    // limit, or a level worse than the limit price
                    if ((p_reg == '0) || (rem_reg == '0) ||
                        (touched_reg >= levels) || beyond)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_W_TAKE;
                end
                S_W_TAKE:
                begin
                    rem_reg     <= rem_reg - fill;
                    filled_reg  <= filled_reg + fill;
                    tq_reg      <= fill;
                    last_reg    <= p_reg;
                    touched_reg <= touched_reg + LVL_W'(1);
                    state_reg   <= (newq == '0) ? S_W_SRCH : S_W_EMIT;
                end
                S_W_SRCH:
                begin
                    if (side_reg && bid_res.valid)
                    begin
                        bid_top_reg <= bid_res.found ? bid_res.idx : '0;
                        state_reg   <= S_W_EMIT;
                    end
                    else if (!side_reg && ask_res.valid)
                    begin
                        ask_top_reg <= ask_res.found ? ask_res.idx : '0;
                        state_reg   <= S_W_EMIT;
                    end
                end
                S_W_EMIT:
                begin
                    if (slot_free)
                    begin
                        status_reg    <= ST_TRADE;
                        tp_reg        <= last_reg;
                        oq_reg        <= tq_reg;
                        obb_reg       <= bid_top_reg;
                        oba_reg       <= ask_top_reg;
                        olast_reg     <= last_reg;
                        last_reg_o    <= 1'b0;
                        p_reg         <= opp_best;
                        state_reg     <= S_W_CHECK;
                    end
                end
                S_FIN:
                begin
                    state_reg <= ((kind_reg == K_LIMIT) && (rem_reg != '0)) ? S_R_ADD
                                                                             : S_F_EMIT;
                end
                S_R_ADD:
                begin
                    // resting lots make the level nonzero, so best moves to it if better
                    if (!side_reg)
                    begin
                        if ((bid_top_reg == '0) || (price_reg > bid_top_reg))
                            bid_top_reg <= price_reg;
                    end
                    else
                    begin
                        if ((ask_top_reg == '0) || (price_reg < ask_top_reg))
                            ask_top_reg <= price_reg;
                    end
                    state_reg <= S_F_EMIT;
                end
                S_F_EMIT:
                begin
                    if (slot_free)
                    begin
                        if (rem_reg == '0)
                            status_reg <= ST_FILLED;
                        else if (filled_reg != '0)
                            status_reg <= ST_PARTIAL;
                        else if (kind_reg == K_LIMIT)
                            status_reg <= ST_RESTED;
                        else
                            status_reg <= ST_REJECT;
                        tp_reg     <= '0;
                        oq_reg     <= filled_reg;
                        obb_reg    <= bid_top_reg;
                        oba_reg    <= ask_top_reg;
                        olast_reg  <= last_reg;
                        last_reg_o <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign trade_price      = tp_reg;
    assign trade_quantity   = oq_reg;
    assign best_bid_out     = obb_reg;
    assign best_ask_out     = oba_reg;
    assign last_trade_price = olast_reg;
    assign last             = last_reg_o;

endmodule

### rtl/obm_checker.sv
// port-level checker for the order book matcher, bound to the top level
module obm_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic [2:0]      status,
    input obm_pkg::price_t trade_price,
    input obm_pkg::qty_t   trade_quantity,
    input logic            last
);
    import obm_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(trade_quantity) && $stable(last))
        else $error("stalled result changed");

    // trades carry a real level and lots, and are never final
    a_trade: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_TRADE) |->
        !last && (trade_price != '0) && (trade_quantity != '0))
        else $error("bad trade transaction");

    // a status transaction is always the final one and has no level price
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_TRADE) |-> last && (trade_price == '0))
        else $error("bad status transaction");

    // one order at a time: no transaction taken right after another
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

endmodule

bind price_level_order_book_matcher obm_checker u_obm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .trade_price(trade_price), .trade_quantity(trade_quantity), .last(last)
);
